// ===== rtl/adohm_pkg.sv =====
// Package for the auto-ranging divider ohmmeter.
// Holds field widths, register indexes, reset values and the controller/datapath structs.
// Depends on nothing.
package adohm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int THR_W    = 13;
    localparam int REF_W    = 24;
    localparam int RES_W    = 36;
    localparam int RANGE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_RANGES = 4;

    localparam logic [RANGE_W-1:0] LAST_RANGE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_OHMS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_OHMS1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_OHMS2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_OHMS3 = 3'd4;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 13'd2483;
    localparam logic [REF_W-1:0] REF_OHMS0_RST = 24'd12322300;
    localparam logic [REF_W-1:0] REF_OHMS1_RST = 24'd1232230;
    localparam logic [REF_W-1:0] REF_OHMS2_RST = 24'd106230;
    localparam logic [REF_W-1:0] REF_OHMS3_RST = 24'd6830;

    typedef struct packed {
        logic acc;
        logic avg_load;
        logic decide;
        logic res_start;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last_sample;
        logic div_done;
        logic switch_rng;
        logic over_scale;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/adohm_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
// Used by the ohmmeter datapath for the resistance quotient.
// Depends on nothing.
module adohm_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_rem_sh;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[NUM_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        w_diff   = w_rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/adohm_ctrl.sv =====
// Controller state machine of the ohmmeter: sequences sample intake, the resistance
// division and the result hand-off. Depends on adohm_pkg for the command and status structs.
module adohm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  adohm_pkg::t_sts i_sts,
    output adohm_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_ACC    = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd2;
    localparam logic [2:0] S_RSTART = 3'd3;
    localparam logic [2:0] S_RES    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_ACC: begin
                o_cmd.acc      = i_in_valid;
                o_cmd.avg_load = i_in_valid && i_sts.last_sample;
                if (i_in_valid && i_sts.last_sample) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                if (i_sts.switch_rng || i_sts.over_scale) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                o_cmd.res_start = 1'b1;
                n_state         = S_RES;
            end
            S_RES: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_ACC);

    a_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_RES))
        else $error("divider finished outside a division state");

endmodule

// ===== rtl/adohm_dp.sv =====
// Datapath of the ohmmeter: configuration registers, sample accumulator with a reciprocal
// multiplier for the average, range register, product register, divider and output register.
// Depends on adohm_pkg and adohm_div.
module adohm_dp #(
    parameter int SAMPLES_PER_AVERAGE = 8,
    parameter int ADC_FULL_SCALE      = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [adohm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [adohm_pkg::REF_W-1:0]         i_cfg_data,
    input  logic [adohm_pkg::SAMPLE_W-1:0]      i_adc_sample,
    input  adohm_pkg::t_cmd                     i_cmd,
    output adohm_pkg::t_sts                     o_sts,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic                                o_final_res,
    output logic [adohm_pkg::RANGE_W-1:0]       o_range_index,
    output logic [adohm_pkg::AVG_W-1:0]         o_average_code,
    output logic [adohm_pkg::RES_W-1:0]         o_resistance_ohms
);

    localparam int SUM_W  = $clog2(4095 * SAMPLES_PER_AVERAGE + 1);
    localparam int CNT_W  = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
    localparam int FS_W   = $clog2(ADC_FULL_SCALE + 1);
    localparam int DEN_W  = FS_W;
    localparam int RES_W  = adohm_pkg::RES_W;
    localparam int LOG_N  = $clog2(SAMPLES_PER_AVERAGE);
    localparam int REC_SH = SUM_W + LOG_N;
    localparam int REC_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + REC_W;
    // The rounded-up reciprocal gives the exact truncated quotient for every sum.
    localparam logic [REC_W-1:0] REC_M = REC_W'(((64'd1 << REC_SH)
        + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE));

    logic [adohm_pkg::THR_W-1:0]   r_thr;
    logic [adohm_pkg::REF_W-1:0]   r_ref [adohm_pkg::NUM_RANGES];
    logic [SUM_W-1:0]              r_sum;
    logic [CNT_W-1:0]              r_cnt;
    logic [adohm_pkg::RANGE_W-1:0] r_range;
    logic [adohm_pkg::AVG_W-1:0]   r_avg;
    logic [RES_W-1:0]              r_prod;
    logic                          r_final;
    logic                          r_sat;
    logic [adohm_pkg::RANGE_W-1:0] r_res_range;
    logic                          r_out_valid;
    logic                          r_out_final;
    logic [adohm_pkg::RANGE_W-1:0] r_out_range;
    logic [adohm_pkg::AVG_W-1:0]   r_out_avg;
    logic [RES_W-1:0]              r_out_res;

    logic [SUM_W-1:0]            w_total;
    logic [PROD_W-1:0]           w_avg_prod;
    logic [adohm_pkg::AVG_W-1:0] w_avg;
    logic                        w_div_start;
    logic [RES_W-1:0]            w_div_num;
    logic [DEN_W-1:0]            w_div_den;
    logic                        w_div_done;
    logic [RES_W-1:0]            w_div_quo;
    logic                        w_switch;
    logic                        w_over;
    logic                        w_out_free;

    always_comb begin
        w_total     = r_sum + SUM_W'(i_adc_sample);
        w_avg_prod  = PROD_W'(w_total) * PROD_W'(REC_M);
        w_avg       = w_avg_prod[REC_SH +: adohm_pkg::AVG_W];
        w_switch    = (adohm_pkg::THR_W'(r_avg) < r_thr) && (r_range != adohm_pkg::LAST_RANGE);
        w_over      = (32'(r_avg) >= 32'(ADC_FULL_SCALE));
        w_out_free  = !r_out_valid || !i_out_stall;
        w_div_start = i_cmd.res_start;
        w_div_num   = r_prod;
        w_div_den   = DEN_W'(32'(ADC_FULL_SCALE) - 32'(r_avg));
    end

    adohm_div #(
        .NUM_W (RES_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= adohm_pkg::THRESHOLD_RST;
            r_ref[0] <= adohm_pkg::REF_OHMS0_RST;
            r_ref[1] <= adohm_pkg::REF_OHMS1_RST;
            r_ref[2] <= adohm_pkg::REF_OHMS2_RST;
            r_ref[3] <= adohm_pkg::REF_OHMS3_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                adohm_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_data[adohm_pkg::THR_W-1:0];
                adohm_pkg::CFG_REF_OHMS0: r_ref[0] <= i_cfg_data;
                adohm_pkg::CFG_REF_OHMS1: r_ref[1] <= i_cfg_data;
                adohm_pkg::CFG_REF_OHMS2: r_ref[2] <= i_cfg_data;
                adohm_pkg::CFG_REF_OHMS3: r_ref[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_range     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (o_sts.last_sample) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= w_total;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.decide) begin
                r_range <= w_switch ? r_range + 1'b1 : '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.avg_load) begin
            r_avg <= w_avg;
        end
        if (i_cmd.decide) begin
            r_final     <= !w_switch;
            r_sat       <= w_over;
            r_res_range <= w_switch ? r_range + 1'b1 : r_range;
            r_prod      <= RES_W'(r_ref[r_range]) * RES_W'(r_avg);
        end
        if (i_cmd.emit) begin
            r_out_final <= r_final;
            r_out_range <= r_res_range;
            r_out_avg   <= r_avg;
            if (!r_final) begin
                r_out_res <= '0;
            end else if (r_sat) begin
                r_out_res <= '1;
            end else begin
                r_out_res <= w_div_quo;
            end
        end
    end

    always_comb begin
        o_sts.last_sample = (r_cnt == CNT_W'(SAMPLES_PER_AVERAGE - 1));
        o_sts.div_done    = w_div_done;
        o_sts.switch_rng  = w_switch;
        o_sts.over_scale  = w_over;
        o_sts.out_free    = w_out_free;
    end

    assign o_out_valid       = r_out_valid;
    assign o_final_res       = r_out_final;
    assign o_range_index     = r_out_range;
    assign o_average_code    = r_out_avg;
    assign o_resistance_ohms = r_out_res;

    a_final_resets_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide && !w_switch |=> r_range == '0)
        else $error("range not returned to zero after a final result");

    a_switch_steps_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide && w_switch |=> r_range == $past(r_range) + 1'b1 && r_range != '0)
        else $error("range switch did not step to the next range");

    a_switch_zero_ohms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_final |-> r_out_res == '0)
        else $error("range switch word carries a nonzero resistance");

endmodule

// ===== rtl/autorange_divider_ohmmeter.sv =====
// Top level of the auto-ranging divider ohmmeter.
// Depends on adohm_pkg, adohm_ctrl, adohm_dp (which holds adohm_div).
//
// Input channel: one 12-bit ADC sample per word on i_adc_sample, taken when i_in_valid
// is high and o_in_stall is low. Samples are accepted one per cycle until a group of
// SAMPLES_PER_AVERAGE is complete; o_in_stall then stays high while the group is
// processed.
// Output channel: one word per group, held in an output register until taken when
// o_out_valid is high and i_out_stall is low. A range switch word has o_final_res low,
// names the new range and carries zero ohms; a final word gives the resistance and the
// range it used, after which the range returns to zero.
// Processing: after the edge that takes the last sample of a group, a final word passes
// through the decide, division start and division states, where a restoring divider
// retires one quotient bit per cycle, and then the emit state; a switch word or an
// over-scale final word goes from decide straight to emit. Intake resumes once the word
// is loaded into the output register; a stalled word holds back the next word's hand-off.
// Configuration: i_cfg_valid/o_cfg_ready write threshold (index 0) and the four
// reference resistances (indexes 1 to 4); o_cfg_ready is always high.
// Reset: synchronous on i_rst_n low; range 0, empty accumulator, no word pending and
// configuration at its default values.
module autorange_divider_ohmmeter #(
    parameter int SAMPLES_PER_AVERAGE = 8,
    parameter int ADC_FULL_SCALE      = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [adohm_pkg::SAMPLE_W-1:0]      i_adc_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_final_res,
    output logic [adohm_pkg::RANGE_W-1:0]       o_range_index,
    output logic [adohm_pkg::AVG_W-1:0]         o_average_code,
    output logic [adohm_pkg::RES_W-1:0]         o_resistance_ohms,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [adohm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [adohm_pkg::REF_W-1:0]         i_cfg_data
);

    adohm_pkg::t_cmd w_cmd;
    adohm_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    adohm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    adohm_dp #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
        .ADC_FULL_SCALE      (ADC_FULL_SCALE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_adc_sample      (i_adc_sample),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_final_res       (o_final_res),
        .o_range_index     (o_range_index),
        .o_average_code    (o_average_code),
        .o_resistance_ohms (o_resistance_ohms)
    );

endmodule
